// File: rtl/core/gda_pkg.sv
// Package with the shared types, constants and calendar functions of the date adder.
package gda_pkg;

  localparam int CountBitsDef = 16;
  localparam int DayBits      = 5;
  localparam int MonthBits    = 4;
  localparam int InYearBits   = 12;
  localparam int CycleBits    = 9;

  localparam int YearMin      = 1970;
  localparam int YearMax      = 2099;
  localparam int CycleBase    = 2000;
  localparam int PrevCycle    = 1600;
  localparam int CycleLen     = 400;
  localparam int CenturyLen   = 100;
  localparam int FebShort     = 28;
  localparam int FebLong      = 29;

  localparam logic [MonthBits-1:0] MonthJan = 4'd1;
  localparam logic [MonthBits-1:0] MonthFeb = 4'd2;
  localparam logic [MonthBits-1:0] MonthApr = 4'd4;
  localparam logic [MonthBits-1:0] MonthJun = 4'd6;
  localparam logic [MonthBits-1:0] MonthSep = 4'd9;
  localparam logic [MonthBits-1:0] MonthNov = 4'd11;
  localparam logic [MonthBits-1:0] MonthDec = 4'd12;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StRun,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } status_t;

  // The argument is the year modulo 400; 4 and 100 divide 400, so it settles every rule.
  function automatic logic is_leap(input logic [CycleBits-1:0] r);
    is_leap = (r[1:0] == 2'b00) &&
              (r != CycleBits'(CenturyLen)) &&
              (r != CycleBits'(2 * CenturyLen)) &&
              (r != CycleBits'(3 * CenturyLen));
  endfunction

  function automatic logic [DayBits-1:0] month_len(input logic [MonthBits-1:0] m,
                                                   input logic leap);
    case (m) inside
      MonthFeb: month_len = leap ? DayBits'(FebLong) : DayBits'(FebShort);
      MonthApr, MonthJun, MonthSep, MonthNov: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

endpackage

// File: rtl/core/gda_ctrl.sv
// Controller state machine that sequences load, check and month steps of the date adder.
module gda_ctrl
  import gda_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StCheck;
        end
      end
      StCheck: state_d = StRun;
      StRun: begin
        if (status_i.count_zero) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StCheck: cmd_o.check = 1'b1;
      StRun:   cmd_o.step  = !status_i.count_zero;
      StDone:  out_valid_o = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/core/gda_dp.sv
// Datapath that holds the date and the remaining count, checks the date and advances them by at most one month a step.
module gda_dp
  import gda_pkg::*;
#(
  parameter int CountBits = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [DayBits-1:0]    in_day_i,
  input  logic [MonthBits-1:0]  in_month_i,
  input  logic [InYearBits-1:0] in_year_i,
  input  logic [CountBits-1:0]  add_count_i,
  output logic [DayBits-1:0]    out_day_o,
  output logic [MonthBits-1:0]  out_month_o,
  output logic [InYearBits-1:0] out_year_o,
  output logic                  was_replaced_o
);

  localparam int YearBits = $clog2(YearMax + 1 + (2 ** CountBits) / 365 + 2);

  logic [DayBits-1:0]   day_q, day_d;
  logic [MonthBits-1:0] month_q, month_d;
  logic [YearBits-1:0]  year_q, year_d;
  logic [CycleBits-1:0] cyc_q, cyc_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 bad_q, bad_d;

  logic [CycleBits-1:0] cyc_in;
  logic [DayBits-1:0]   len;
  logic [DayBits-1:0]   left;
  logic [CountBits-1:0] left_ext;
  logic                 date_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    cyc_q   <= cyc_d;
    bad_q   <= bad_d;
  end

  always_comb begin
    if (year_q >= YearBits'(CycleBase)) begin
      cyc_in = CycleBits'(year_q - YearBits'(CycleBase));
    end else begin
      cyc_in = CycleBits'(year_q - YearBits'(PrevCycle));
    end
  end

  assign len = cmd_i.check ? month_len(month_q, is_leap(cyc_in))
                           : month_len(month_q, is_leap(cyc_q));
  assign left     = len - day_q;
  assign left_ext = CountBits'(left);

  assign date_ok = (year_q >= YearBits'(YearMin)) && (year_q <= YearBits'(YearMax)) &&
                   (month_q >= MonthJan) && (month_q <= MonthDec) &&
                   (day_q != '0) && (day_q <= len);

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    cyc_d   = cyc_q;
    count_d = count_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      day_d   = in_day_i;
      month_d = in_month_i;
      year_d  = YearBits'(in_year_i);
      count_d = add_count_i;
    end else if (cmd_i.check) begin
      if (date_ok) begin
        cyc_d = cyc_in;
        bad_d = 1'b0;
      end else begin
        day_d   = DayBits'(1);
        month_d = MonthJan;
        year_d  = YearBits'(YearMin);
        cyc_d   = CycleBits'(YearMin - PrevCycle);
        bad_d   = 1'b1;
      end
    end else if (cmd_i.step) begin
      if (count_q <= left_ext) begin
        day_d   = day_q + DayBits'(count_q);
        count_d = '0;
      end else begin
        count_d = count_q - left_ext - CountBits'(1);
        day_d   = DayBits'(1);
        if (month_q == MonthDec) begin
          month_d = MonthJan;
          year_d  = year_q + YearBits'(1);
          cyc_d   = (cyc_q == CycleBits'(CycleLen - 1)) ? '0 : cyc_q + CycleBits'(1);
        end else begin
          month_d = month_q + MonthBits'(1);
        end
      end
    end
  end

  assign status_o.count_zero = (count_q == '0);

  assign out_day_o      = day_q;
  assign out_month_o    = month_q;
  assign out_year_o     = year_q[InYearBits-1:0];
  assign was_replaced_o = bad_q;

endmodule

// File: rtl/core/gregorian_date_add_days.sv
// A beat is loaded in idle and checked; run then crosses one month boundary per step, with
// one more step when days remain after the last crossing, and done offers the result beat.
// One beat at a time: the next input beat is taken in the cycle after the result beat.
// The datapath's month-step loop paces a beat: each cycle advances at most one month.
// Reset: rst_ni clears the controller to idle and the count; date registers need no reset.
// Module that adds a day count to a checked Gregorian date.
module gregorian_date_add_days
  import gda_pkg::*;
#(
  parameter int CountBits = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DayBits-1:0]    in_day_i,
  input  logic [MonthBits-1:0]  in_month_i,
  input  logic [InYearBits-1:0] in_year_i,
  input  logic [CountBits-1:0]  add_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DayBits-1:0]    out_day_o,
  output logic [MonthBits-1:0]  out_month_o,
  output logic [InYearBits-1:0] out_year_o,
  output logic                  was_replaced_o
);

  cmd_t    cmd;
  status_t status;

  gda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gda_dp #(
    .CountBits(CountBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_day_i      (in_day_i),
    .in_month_i    (in_month_i),
    .in_year_i     (in_year_i),
    .add_count_i   (add_count_i),
    .out_day_o     (out_day_o),
    .out_month_o   (out_month_o),
    .out_year_o    (out_year_o),
    .was_replaced_o(was_replaced_o)
  );

endmodule

// File: dv/gregorian_date_add_days_checker.sv
// Checker that predicts the date adder's result beats and compares them field by field.
`timescale 1ns / 100ps
module gregorian_date_add_days_checker
  import gda_pkg::*;
#(
  parameter int CountBits = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [DayBits-1:0]    in_day_i,
  input  logic [MonthBits-1:0]  in_month_i,
  input  logic [InYearBits-1:0] in_year_i,
  input  logic [CountBits-1:0]  add_count_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [DayBits-1:0]    out_day_i,
  input  logic [MonthBits-1:0]  out_month_i,
  input  logic [InYearBits-1:0] out_year_i,
  input  logic                  was_replaced_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [DayBits-1:0]    day;
    logic [MonthBits-1:0]  month;
    logic [InYearBits-1:0] year;
    logic                  replaced;
  } date_t;

  date_t due_dates_q[$];

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    bit leap;
    leap = (y % CycleLen == 0) || ((y % 4 == 0) && (y % CenturyLen != 0));
    if (m == MonthFeb) begin
      return leap ? FebLong : FebShort;
    end
    if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic date_t date_after(input logic [DayBits-1:0] d_in,
                                       input logic [MonthBits-1:0] m_in,
                                       input logic [InYearBits-1:0] y_in,
                                       input logic [CountBits-1:0] n_in);
    int unsigned d, m, y, n, left;
    date_t r;
    d = d_in;
    m = m_in;
    y = y_in;
    n = n_in;
    r.replaced = 1'b0;
    if (y < YearMin || y > YearMax || m < MonthJan || m > MonthDec || d < 1 ||
        d > days_in_month(m, y)) begin
      d = 1;
      m = MonthJan;
      y = YearMin;
      r.replaced = 1'b1;
    end
    while (n > 0) begin
      left = days_in_month(m, y) - d;
      if (n <= left) begin
        d += n;
        n = 0;
      end else begin
        n -= left + 1;
        d = 1;
        if (m == MonthDec) begin
          m = MonthJan;
          y++;
        end else begin
          m++;
        end
      end
    end
    r.day   = DayBits'(d);
    r.month = MonthBits'(m);
    r.year  = InYearBits'(y);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_t want;
    int misses;
    if (!rst_ni) begin
      due_dates_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      misses = 0;
      if (in_valid_i && !in_stall_i) begin
        due_dates_q.push_back(date_after(in_day_i, in_month_i, in_year_i, add_count_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_dates_q.size() == 0) begin
          $error("result beat with no date pending");
          misses++;
        end else begin
          want = due_dates_q.pop_front();
          if (out_day_i !== want.day) begin
            $error("out_day: expected %0d, actual %0d", want.day, out_day_i);
            misses++;
          end
          if (out_month_i !== want.month) begin
            $error("out_month: expected %0d, actual %0d", want.month, out_month_i);
            misses++;
          end
          if (out_year_i !== want.year) begin
            $error("out_year: expected %0d, actual %0d", want.year, out_year_i);
            misses++;
          end
          if (was_replaced_i !== want.replaced) begin
            $error("was_replaced: expected %0d, actual %0d", want.replaced, was_replaced_i);
            misses++;
          end
        end
      end
      fail_count_o <= fail_count_o + misses;
      pending_o    <= due_dates_q.size();
    end
  end

endmodule

// File: dv/gregorian_date_add_days_tb.sv
// Testbench top that drives date beats into the date adder and gives the verdict.
`timescale 1ns / 100ps
module gregorian_date_add_days_tb;
  import gda_pkg::*;

  localparam int RandomBeats = 250;
  localparam int QuietBeats  = 40;
  localparam int DrainCycles = 2400;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [DayBits-1:0]      in_day = '0;
  logic [MonthBits-1:0]    in_month = '0;
  logic [InYearBits-1:0]   in_year = '0;
  logic [CountBitsDef-1:0] add_count = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DayBits-1:0]      out_day;
  logic [MonthBits-1:0]    out_month;
  logic [InYearBits-1:0]   out_year;
  logic                    was_replaced;
  logic                    quiet = 1'b0;
  int                      fail_count;
  int                      pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gregorian_date_add_days DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_day_i      (in_day),
    .in_month_i    (in_month),
    .in_year_i     (in_year),
    .add_count_i   (add_count),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_day_o     (out_day),
    .out_month_o   (out_month),
    .out_year_o    (out_year),
    .was_replaced_o(was_replaced)
  );

  gregorian_date_add_days_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_day_i      (in_day),
    .in_month_i    (in_month),
    .in_year_i     (in_year),
    .add_count_i   (add_count),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_day_i     (out_day),
    .out_month_i   (out_month),
    .out_year_i    (out_year),
    .was_replaced_i(was_replaced),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  task automatic send_date(input int unsigned d, m, y, n);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_day    <= DayBits'(d);
    in_month  <= MonthBits'(m);
    in_year   <= InYearBits'(y);
    add_count <= CountBitsDef'(n);
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned d, m, y, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_date(1, 1, 1970, 0);
    send_date(31, 12, 2099, 0);
    send_date(31, 12, 2099, 65535);
    send_date(1, 1, 1970, 65535);
    send_date(31, 12, 1999, 1);
    send_date(28, 2, 2000, 1);
    send_date(29, 2, 2000, 0);
    send_date(29, 2, 2001, 5);
    send_date(28, 2, 2099, 1);
    send_date(31, 12, 2099, 60);
    send_date(31, 1, 1970, 0);
    send_date(30, 1, 1970, 1);
    send_date(31, 4, 2020, 3);
    send_date(0, 6, 2050, 10);
    send_date(15, 0, 2000, 10);
    send_date(15, 13, 2000, 10);
    send_date(31, 15, 4095, 65535);
    send_date(0, 0, 0, 0);
    send_date(10, 6, 1969, 1);
    send_date(10, 6, 2100, 1);
    send_date(1, 3, 2024, 365);
    send_date(31, 1, 2024, 29);
    send_date(15, 7, 2010, 32768);

    for (int i = 0; i < RandomBeats; i++) begin
      if (i == RandomBeats - QuietBeats) begin
        quiet = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        y = $urandom_range(YearMin, YearMax);
        m = $urandom_range(MonthJan, MonthDec);
        d = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 28) : $urandom_range(29, 31);
      end else begin
        d = $urandom;
        m = $urandom;
        y = $urandom;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: n = $urandom_range(0, 62);
        5, 6, 7:       n = $urandom_range(0, 1500);
        default:       n = $urandom_range(0, 65535);
      endcase
      send_date(d, m, y, n);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("gregorian_date_add_days_tb passed");
    end else begin
      $display("gregorian_date_add_days_tb failed");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("gregorian_date_add_days_tb failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/gda_pkg.sv
rtl/core/gda_ctrl.sv
rtl/core/gda_dp.sv
rtl/core/gregorian_date_add_days.sv
dv/gregorian_date_add_days_checker.sv
dv/gregorian_date_add_days_tb.sv
